// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the stamped command FIFO.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

// Check that a trigger implies a condition in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define ASSERT_NEXT(label, clk, rst, trig, cond, msg)
`define ASSERT_IMPLY(label, clk, rst, trig, cond, msg)

`endif

`endif

// ===== rtl/sscf_pkg.sv =====
// Package for the stamped command FIFO: request/response structs and codes.
// No dependencies.
`timescale 1ns / 1ps

package sscf_pkg;

   localparam int SEQ_BITS     = 64;
   localparam int WORD_BITS    = 64;
   localparam int LEVEL_BITS   = 9;
   localparam int STATUS_BITS  = 2;

   // Request codes
   localparam logic MODE_ENQ = 1'b0;
   localparam logic MODE_DEQ = 1'b1;

   // Response status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic                 mode;
      logic [WORD_BITS-1:0] in_payload;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [WORD_BITS-1:0]   out_payload;
      logic [SEQ_BITS-1:0]    out_seq;
      logic [LEVEL_BITS-1:0]  fill_level;
   } rsp_type;

endpackage

// ===== rtl/sscf_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sscf_ram #(
   parameter  int DEPTH = 256,
   parameter  int WIDTH = 64,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Hold the read data until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/seq_stamped_command_fifo.sv =====
// An accepted request waits in the pending stage for the RAM read data, then moves into
// the response register once it is free. Throughput: one request per cycle while the
// response side does not stall; a single pending stage keeps the pace.
// Reset: synchronous, active high; clears both ring indices, sets the sequence counter
// to one and empties the pipeline. Entry storage is not cleared (no clearing pass).
// Depends on sscf_pkg, sscf_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module seq_stamped_command_fifo
   import sscf_pkg::*;
#(
   parameter int CAPACITY     = 256,
   parameter int PAYLOAD_BITS = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Indices count modulo twice the capacity so full and empty stay distinct.
   localparam int AW = $clog2(CAPACITY);
   localparam int IW = AW + 1;
   localparam logic [IW-1:0] CAP_I   = IW'(CAPACITY);
   localparam logic [IW-1:0] LAST_I  = IW'(2 * CAPACITY - 1);
   localparam logic [IW:0]   IDX_MOD = (IW + 1)'(2 * CAPACITY);

   // Map a ring index onto its storage slot.
   function automatic logic [AW-1:0] slot_of(input logic [IW-1:0] idx);
      logic [IW-1:0] folded;
      folded = (idx >= CAP_I) ? (idx - CAP_I) : idx;
      return folded[AW-1:0];
   endfunction

   // Step a ring index, wrapping at twice the capacity.
   function automatic logic [IW-1:0] advance(input logic [IW-1:0] idx);
      return (idx == LAST_I) ? '0 : (idx + 1'b1);
   endfunction

   // Ring state
   logic [IW-1:0]       rd_idx_ff, rd_idx_in;
   logic [IW-1:0]       wr_idx_ff, wr_idx_in;
   logic [SEQ_BITS-1:0] next_seq_ff, next_seq_in;

   // Pending stage: waits for the RAM read data
   logic                   pend_ff, pend_in;
   logic                   pend_pop_ff, pend_pop_in;
   logic [STATUS_BITS-1:0] pend_status_ff, pend_status_in;
   logic [SEQ_BITS-1:0]    pend_seq_ff, pend_seq_in;
   logic [LEVEL_BITS-1:0]  pend_fill_ff, pend_fill_in;

   // Response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic [IW:0]             fill_wide;
   logic [IW-1:0]           fill_cnt;
   logic [IW-1:0]           fill_after;
   logic                    is_full;
   logic                    is_empty;
   logic                    req_accept;
   logic                    enq_ok;
   logic                    deq_ok;
   logic                    out_load;
   logic [PAYLOAD_BITS-1:0] ram_rd_data;

   // Fill level from the two indices.
   always_comb begin
      if (wr_idx_ff >= rd_idx_ff) begin
         fill_wide = {1'b0, wr_idx_ff} - {1'b0, rd_idx_ff};
      end else begin
         fill_wide = {1'b0, wr_idx_ff} + IDX_MOD - {1'b0, rd_idx_ff};
      end
      fill_cnt = fill_wide[IW-1:0];
   end

   assign is_full  = (fill_cnt == CAP_I);
   assign is_empty = (fill_cnt == '0);

   // Move the pending request into the response register when that register frees up.
   assign out_load   = pend_ff && (!rsp_valid_ff || !rsp_stall);
   // Stall only while the pending stage cannot drain this cycle.
   assign req_stall  = pend_ff && !out_load;
   assign req_accept = req_valid && !req_stall;
   assign enq_ok     = req_accept && (req_data.mode == MODE_ENQ) && !is_full;
   assign deq_ok     = req_accept && (req_data.mode == MODE_DEQ) && !is_empty;

   // Storage: write on accepted enqueue, read on accepted dequeue.
   sscf_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (PAYLOAD_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (enq_ok),
      .wr_addr (slot_of(wr_idx_ff)),
      .wr_data (req_data.in_payload[PAYLOAD_BITS-1:0]),
      .rd_en   (deq_ok),
      .rd_addr (slot_of(rd_idx_ff)),
      .rd_data (ram_rd_data)
   );

   // Advance indices and the sequence counter.
   always_comb begin
      wr_idx_in   = enq_ok ? advance(wr_idx_ff) : wr_idx_ff;
      rd_idx_in   = deq_ok ? advance(rd_idx_ff) : rd_idx_ff;
      next_seq_in = enq_ok ? (next_seq_ff + 1'b1) : next_seq_ff;
   end

   // Build the pending response from the state seen at acceptance.
   always_comb begin
      fill_after = fill_cnt;
      if (enq_ok) begin
         fill_after = fill_cnt + 1'b1;
      end else if (deq_ok) begin
         fill_after = fill_cnt - 1'b1;
      end

      pend_in        = req_accept ? 1'b1 : (out_load ? 1'b0 : pend_ff);
      pend_pop_in    = pend_pop_ff;
      pend_status_in = pend_status_ff;
      pend_seq_in    = pend_seq_ff;
      pend_fill_in   = pend_fill_ff;

      if (req_accept) begin
         pend_pop_in  = deq_ok;
         pend_fill_in = LEVEL_BITS'(fill_after);
         if (req_data.mode == MODE_ENQ) begin
            pend_status_in = is_full ? STATUS_FULL : STATUS_OK;
            pend_seq_in    = next_seq_ff;
         end else if (is_empty) begin
            pend_status_in = STATUS_EMPTY;
            pend_seq_in    = '0;
         end else begin
            pend_status_in = STATUS_OK;
            pend_seq_in    = next_seq_ff - SEQ_BITS'(fill_cnt);
         end
      end
   end

   // Response register: load from the pending stage, drop once taken.
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.status      = pend_status_ff;
         rsp_data_in.out_payload = pend_pop_ff ? WORD_BITS'(ram_rd_data) : '0;
         rsp_data_in.out_seq     = pend_seq_ff;
         rsp_data_in.fill_level  = pend_fill_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         next_seq_ff  <= SEQ_BITS'(1);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_idx_ff    <= rd_idx_in;
         wr_idx_ff    <= wr_idx_in;
         next_seq_ff  <= next_seq_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_pop_ff    <= pend_pop_in;
      pend_status_ff <= pend_status_in;
      pend_seq_ff    <= pend_seq_in;
      pend_fill_ff   <= pend_fill_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   `ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_cnt <= CAP_I,
                  "fill count exceeds capacity")
   `ASSERT_IMPLY(a_fail_no_payload, clock, reset,
                 rsp_valid && (rsp_data.status != STATUS_OK),
                 rsp_data.out_payload == '0, "failed response carries a payload")
   `ASSERT_NEXT(a_seq_step, clock, reset, enq_ok,
                next_seq_ff == $past(next_seq_ff) + 1'b1,
                "sequence did not advance on enqueue")
   `ASSERT_NEXT(a_pend_hold, clock, reset, pend_ff && !out_load, pend_ff,
                "pending response lost while stalled")

endmodule
